### rtl/weighted_histogram_nearest_bin_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the weighted histogram block
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_HISTOGRAM_NEAREST_BIN_TOP_DEFINES_SVH
`define WEIGHTED_HISTOGRAM_NEAREST_BIN_TOP_DEFINES_SVH

// Same-cycle implication.
`define WHNB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("whnb assertion failed");

// Next-cycle implication.
`define WHNB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("whnb assertion failed");

`endif

### rtl/whnb_pkg.sv
// ----------------------------------------------------------------------------
// whnb_pkg
// Shared widths, request and status codes, and sum limits.
// ----------------------------------------------------------------------------
package whnb_pkg;

  localparam int NUM_BINS_DEFAULT = 64;

  localparam int SEL_W   = 6;
  localparam int VALUE_W = 32;
  localparam int SUM_W   = 48;
  localparam int CFG_W   = 7;

  localparam logic [CFG_W-1:0]          BINS_RESET = 7'd64;
  localparam logic signed [VALUE_W-1:0] ONE_Q16    = 32'sh0001_0000;
  localparam logic [SUM_W-1:0]          SUM_MAX    = 48'h7FFF_FFFF_FFFF;
  localparam logic [SUM_W-1:0]          SUM_MIN    = 48'h8000_0000_0000;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_SAT   = 2'd2
  } status_t;

endpackage

### rtl/whnb_if.sv
// ----------------------------------------------------------------------------
// whnb_req_if / whnb_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface whnb_req_if;
  logic                                       valid;
  logic                                       ready;
  logic [1:0]                                 req_type;
  logic [whnb_pkg::SEL_W-1:0]                 bin_select;
  logic signed [whnb_pkg::VALUE_W-1:0]        sample_value;
  logic signed [whnb_pkg::VALUE_W-1:0]        sample_weight;
  logic                                       use_weight;

  modport source (output valid, req_type, bin_select, sample_value, sample_weight,
                  use_weight, input ready);
  modport sink   (input valid, req_type, bin_select, sample_value, sample_weight,
                  use_weight, output ready);
endinterface

interface whnb_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [whnb_pkg::SEL_W-1:0]          chosen_bin;
  logic signed [whnb_pkg::SUM_W-1:0]   bin_sum;
  logic [1:0]                          status;

  modport source (output valid, chosen_bin, bin_sum, status, input ready);
  modport sink   (input valid, chosen_bin, bin_sum, status, output ready);
endinterface

### rtl/whnb_ram.sv
// ----------------------------------------------------------------------------
// whnb_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module whnb_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/weighted_histogram_nearest_bin_top.sv
// ----------------------------------------------------------------------------
// weighted_histogram_nearest_bin_top
// Histogram with nearest-center binning over a center memory and a sum memory.
//
// One request item is taken at a time and gives exactly one result item. Load
// and read do one sum memory read. An add scans the centers in use through
// the single read port of the center memory, one entry per cycle, and counts
// the midpoint borders strictly below the sample. Its steps are the accept,
// the scan with the pending center read at its end, the sum read, and the
// saturating update and write-back. A clear sweeps the sum memory one entry
// per cycle. After reset the same sweep runs before the first request is
// taken; configuration writes are taken at any time. A finished result sits
// in an output register, so the next request is taken while it waits; an
// item that finishes while the previous result is still stalled holds until
// it drains. bins_in_use is clamped to [2, NUM_BINS]; load or read beyond
// that returns status "index out of range" and a zero sum. Sums saturate at
// 48 bits.
// ----------------------------------------------------------------------------
`include "weighted_histogram_nearest_bin_top_defines.svh"

module weighted_histogram_nearest_bin_top #(
  parameter int NUM_BINS = whnb_pkg::NUM_BINS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  whnb_req_if.sink                      req,
  whnb_rsp_if.source                    rsp,
  input  logic                          cfg_we,
  input  logic [whnb_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int IDX_W = $clog2(NUM_BINS);
  localparam int CW    = whnb_pkg::CFG_W;
  localparam int VW    = whnb_pkg::VALUE_W;
  localparam int SW    = whnb_pkg::SUM_W;
  localparam int SELW  = whnb_pkg::SEL_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SUM_RD,
    ST_SUM_UPD,
    ST_FETCH
  } state_t;

  state_t state;

  // Configuration and latched request fields.
  logic [CW-1:0]          bins_cfg;
  logic [SELW-1:0]        sel_q;
  logic                   oor_q;
  logic signed [VW:0]     twice_q;
  logic signed [VW-1:0]   add_q;

  // Clear sweep.
  logic [IDX_W-1:0]       clr_idx;
  logic                   clr_resp;

  // Center scan.
  logic [CW-1:0]          scan_idx;
  logic                   rd_pend;
  logic [CW-1:0]          rd_k;
  logic signed [VW-1:0]   prev_c;
  logic [CW-1:0]          bin_cnt;

  // Result register.
  logic                   rsp_valid;
  logic [SELW-1:0]        rsp_bin;
  logic [SW-1:0]          rsp_sum;
  whnb_pkg::status_t      rsp_status;

  // Memory ports.
  logic                   center_we;
  logic [IDX_W-1:0]       center_waddr;
  logic [IDX_W-1:0]       center_raddr;
  logic [VW-1:0]          center_rdata;
  logic                   sum_we;
  logic [IDX_W-1:0]       sum_waddr;
  logic [SW-1:0]          sum_wdata;
  logic [IDX_W-1:0]       sum_raddr;
  logic [SW-1:0]          sum_rdata;

  // Datapath.
  logic [CW-1:0]          n_eff;
  logic                   accept;
  logic                   in_oor;
  logic                   slot_free;
  logic                   rsp_load;
  logic                   clr_last;
  logic signed [VW:0]     pair;
  logic                   below;
  logic signed [SW:0]     sum_full;
  logic                   sat;
  logic [SW-1:0]          sat_sum;

  // Clamp the bin count register to [2, NUM_BINS].
  always_comb begin
    if (bins_cfg < CW'(2)) begin
      n_eff = CW'(2);
    end else if (int'(bins_cfg) > NUM_BINS) begin
      n_eff = CW'(NUM_BINS);
    end else begin
      n_eff = bins_cfg;
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign in_oor    = {1'b0, req.bin_select} >= n_eff;
  assign slot_free = !rsp_valid || rsp.ready;
  assign clr_last  = (clr_idx == IDX_W'(NUM_BINS - 1));

  // A new result enters the output register this cycle.
  assign rsp_load = slot_free && ((state == ST_SUM_UPD) || (state == ST_FETCH) ||
                                  ((state == ST_CLEAR) && clr_last && clr_resp));

  assign rsp.valid      = rsp_valid;
  assign rsp.chosen_bin = rsp_bin;
  assign rsp.bin_sum    = rsp_sum;
  assign rsp.status     = rsp_status;

  // Exact border test: c[k-1] + c[k] < 2 * sample, all in 33 bits.
  assign pair  = (VW+1)'(prev_c) + (VW+1)'($signed(center_rdata));
  assign below = pair < twice_q;

  // Saturating add; overflow shows as a mismatch of the top two bits.
  assign sum_full = (SW+1)'($signed(sum_rdata)) + (SW+1)'(add_q);
  assign sat      = sum_full[SW] != sum_full[SW-1];
  assign sat_sum  = sat ? (sum_full[SW] ? whnb_pkg::SUM_MIN : whnb_pkg::SUM_MAX)
                        : sum_full[SW-1:0];

  // Memory port steering by state.
  always_comb begin
    center_we    = 1'b0;
    center_waddr = IDX_W'(req.bin_select);
    center_raddr = IDX_W'(scan_idx);
    sum_we       = 1'b0;
    sum_waddr    = clr_idx;
    sum_wdata    = '0;
    sum_raddr    = IDX_W'(sel_q);
    case (state)
      ST_CLEAR: begin
        sum_we = 1'b1;
      end
      ST_IDLE: begin
        // Read the sum now so it is ready in the fetch cycle.
        sum_raddr = IDX_W'(req.bin_select);
        center_we = accept && (req.req_type == whnb_pkg::REQ_LOAD) && !in_oor;
      end
      ST_SUM_RD: begin
        sum_raddr = IDX_W'(bin_cnt);
      end
      ST_SUM_UPD: begin
        // Write back only when the result can leave, so the update and the
        // result happen together and the next item sees the new sum.
        sum_raddr = IDX_W'(bin_cnt);
        sum_waddr = IDX_W'(bin_cnt);
        sum_wdata = sat_sum;
        sum_we    = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      clr_resp  <= 1'b0;
      rsp_valid <= 1'b0;
      rd_pend   <= 1'b0;
      bins_cfg  <= whnb_pkg::BINS_RESET;
    end else begin
      if (cfg_we) begin
        bins_cfg <= cfg_wdata;
      end
      // Drop the result once it transfers, unless a new result loads.
      if (rsp_valid && rsp.ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          if (!clr_last) begin
            clr_idx <= clr_idx + IDX_W'(1);
          end else if (!clr_resp) begin
            state <= ST_IDLE;
          end else if (slot_free) begin
            rsp_valid  <= 1'b1;
            rsp_bin    <= '0;
            rsp_sum    <= '0;
            rsp_status <= whnb_pkg::STATUS_OK;
            clr_resp   <= 1'b0;
            state      <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (accept) begin
            sel_q   <= req.bin_select;
            oor_q   <= in_oor;
            twice_q <= {req.sample_value, 1'b0};
            add_q   <= req.use_weight ? req.sample_weight : whnb_pkg::ONE_Q16;
            case (req.req_type)
              whnb_pkg::REQ_CLEAR: begin
                clr_idx  <= '0;
                clr_resp <= 1'b1;
                state    <= ST_CLEAR;
              end
              whnb_pkg::REQ_ADD: begin
                scan_idx <= '0;
                rd_pend  <= 1'b0;
                bin_cnt  <= '0;
                state    <= ST_SCAN;
              end
              default: begin
                state <= ST_FETCH;
              end
            endcase
          end
        end

        ST_SCAN: begin
          // Issue one center read per cycle; compare it in the next cycle.
          rd_pend <= scan_idx < n_eff;
          rd_k    <= scan_idx;
          if (scan_idx < n_eff) begin
            scan_idx <= scan_idx + CW'(1);
          end
          if (rd_pend) begin
            prev_c <= $signed(center_rdata);
            if ((rd_k != '0) && below) begin
              bin_cnt <= bin_cnt + CW'(1);
            end
            if (rd_k == n_eff - CW'(1)) begin
              state <= ST_SUM_RD;
            end
          end
        end

        ST_SUM_RD: begin
          state <= ST_SUM_UPD;
        end

        ST_SUM_UPD: begin
          if (slot_free) begin
            rsp_valid  <= 1'b1;
            rsp_bin    <= SELW'(bin_cnt);
            rsp_sum    <= sat_sum;
            rsp_status <= sat ? whnb_pkg::STATUS_SAT : whnb_pkg::STATUS_OK;
            state      <= ST_IDLE;
          end
        end

        ST_FETCH: begin
          if (slot_free) begin
            rsp_valid  <= 1'b1;
            rsp_bin    <= sel_q;
            rsp_sum    <= oor_q ? '0 : sum_rdata;
            rsp_status <= oor_q ? whnb_pkg::STATUS_RANGE : whnb_pkg::STATUS_OK;
            state      <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  whnb_ram #(
    .WIDTH  (VW),
    .DEPTH  (NUM_BINS),
    .ADDR_W (IDX_W)
  ) u_center_ram (
    .clk   (clk),
    .we    (center_we),
    .waddr (center_waddr),
    .wdata (req.sample_value),
    .raddr (center_raddr),
    .rdata (center_rdata)
  );

  whnb_ram #(
    .WIDTH  (SW),
    .DEPTH  (NUM_BINS),
    .ADDR_W (IDX_W)
  ) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  // The border count never reaches the number of bins in use.
  `WHNB_ASSERT_NOW(a_cnt_in_range, state == ST_SCAN, bin_cnt < n_eff)
  // An out-of-range result carries a zero sum.
  `WHNB_ASSERT_NOW(a_range_zero, rsp.valid && (rsp.status == whnb_pkg::STATUS_RANGE),
                   rsp.bin_sum == '0)
  // A finished add presents the bin it wrote back.
  `WHNB_ASSERT_NEXT(a_add_result, (state == ST_SUM_UPD) && slot_free,
                    rsp.valid && (rsp.chosen_bin == SELW'($past(bin_cnt))))

endmodule
